// ===== hdl/signal_disposition_mask_unit_macros.svh =====
// Assertion macros shared by the signal disposition mask unit RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SIGNAL_DISPOSITION_MASK_UNIT_MACROS_SVH
`define SIGNAL_DISPOSITION_MASK_UNIT_MACROS_SVH

// same-cycle implication
`define SDM_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdm assertion failed");

// next-cycle implication
`define SDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdm assertion failed");

`endif

// ===== hdl/sdm_pkg.sv =====
// Types, constants and codes of the signal disposition mask unit.
// No dependencies; used by sdm_action_ram, sdm_engine and the top level.
package sdm_pkg;

   localparam int MAX_SIG_DEFAULT = 63;
   localparam int MASK_W          = 64;
   localparam int MASK_IDX_W      = 6;

   localparam logic [31:0] FL_SUPPORTED = 32'hD800_0007;
   localparam logic [31:0] FL_NODEFER   = 32'h4000_0000;
   localparam logic [31:0] FL_RESETHAND = 32'h8000_0000;

   localparam logic [63:0] UNBLOCKABLE = 64'h0000_0000_0008_0200;
   localparam logic [63:0] TERM_SET    = 64'h0000_0000_AF00_FFFE;
   localparam logic [63:0] CORE_SET    = 64'h0000_0000_8300_09F8;
   localparam logic [63:0] LOW_WORD    = 64'h0000_0000_FFFF_FFFF;

   localparam logic [7:0]  EXIT_BASE   = 8'd128;
   localparam logic [63:0] HANDLER_DFL = 64'd0;
   localparam logic [63:0] HANDLER_IGN = 64'd1;

   localparam logic [6:0] SIG_KILL = 7'd9;
   localparam logic [6:0] SIG_STOP = 7'd19;

   localparam logic [3:0] SET_SIZE_4 = 4'd4;
   localparam logic [3:0] SET_SIZE_8 = 4'd8;

   localparam logic [1:0] OP_SET_ACTION   = 2'd0;
   localparam logic [1:0] OP_RESET_ACTION = 2'd1;
   localparam logic [1:0] OP_CHANGE_MASK  = 2'd2;
   localparam logic [1:0] OP_DELIVER      = 2'd3;

   localparam logic [1:0] HOW_BLOCK   = 2'd0;
   localparam logic [1:0] HOW_UNBLOCK = 2'd1;
   localparam logic [1:0] HOW_SETMASK = 2'd2;
   localparam logic [1:0] HOW_BAD     = 2'd3;

   localparam logic [2:0] DISP_HANDLER   = 3'd0;
   localparam logic [2:0] DISP_INVALID   = 3'd1;
   localparam logic [2:0] DISP_BLOCKED   = 3'd2;
   localparam logic [2:0] DISP_IGNORED   = 3'd3;
   localparam logic [2:0] DISP_DFL_IGN   = 3'd4;
   localparam logic [2:0] DISP_TERMINATE = 3'd5;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_INV = 1'b1;

   typedef struct packed {
      logic        installed;
      logic [63:0] handler;
      logic [31:0] flags;
      logic [63:0] amask;
   } action_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  signal_number;
      logic [63:0] handler_value;
      logic [31:0] action_flag_bits;
      logic [63:0] set_value;
      logic [1:0]  mask_how;
      logic        has_new_set;
      logic [3:0]  set_size;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [2:0]  disposition;
      logic [63:0] handler_address;
      logic [31:0] flags_out;
      logic [63:0] action_mask_out;
      logic [63:0] old_signal_mask;
      logic [63:0] new_signal_mask;
      logic [7:0]  exit_value;
      logic        core_dump;
      logic        terminated;
   } rsp_type;

   typedef struct packed {
      logic [63:0] blocked;
      logic        stopped;
      logic [7:0]  exit_value;
   } proc_state_type;

endpackage

// ===== hdl/sdm_if.sv =====
// Request and response channel interfaces of the signal disposition mask unit.
// Valid/ready handshake; no dependencies.
interface sdm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [6:0]  signal_number;
   logic [63:0] handler_value;
   logic [31:0] action_flag_bits;
   logic [63:0] set_value;
   logic [1:0]  mask_how;
   logic        has_new_set;
   logic [3:0]  set_size;

   modport source (
      output valid, opcode, signal_number, handler_value, action_flag_bits,
             set_value, mask_how, has_new_set, set_size,
      input  ready
   );
   modport sink (
      input  valid, opcode, signal_number, handler_value, action_flag_bits,
             set_value, mask_how, has_new_set, set_size,
      output ready
   );
endinterface

interface sdm_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [2:0]  disposition;
   logic [63:0] handler_address;
   logic [31:0] flags_out;
   logic [63:0] action_mask_out;
   logic [63:0] old_signal_mask;
   logic [63:0] new_signal_mask;
   logic [7:0]  exit_value;
   logic        core_dump;
   logic        terminated;

   modport source (
      output valid, status, disposition, handler_address, flags_out,
             action_mask_out, old_signal_mask, new_signal_mask, exit_value,
             core_dump, terminated,
      input  ready
   );
   modport sink (
      input  valid, status, disposition, handler_address, flags_out,
             action_mask_out, old_signal_mask, new_signal_mask, exit_value,
             core_dump, terminated,
      output ready
   );
endinterface

// ===== hdl/sdm_action_ram.sv =====
// Per-signal action table: synchronous memory, one write and one read port.
// Per-entry valid flops make unwritten entries read as zero. Uses sdm_pkg.
module sdm_action_ram #(
   parameter int DEPTH  = sdm_pkg::MAX_SIG_DEFAULT + 1,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output sdm_pkg::action_type  rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  sdm_pkg::action_type  wr_data
);

   sdm_pkg::action_type act_mem_ff [DEPTH];
   sdm_pkg::action_type rd_data_ff;
   logic [DEPTH-1:0]    vld_ff;
   logic [DEPTH-1:0]    vld_in;
   logic                rd_vld_ff;
   logic                rd_vld_in;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   assign rd_vld_in = rd_en ? vld_ff[rd_addr] : rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         act_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= act_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== hdl/sdm_engine.sv =====
// Request evaluation: decodes one request against its action entry and the
// process state, gives the response, table write-back and next state. Uses sdm_pkg.
module sdm_engine #(
   parameter int MAX_SIG = sdm_pkg::MAX_SIG_DEFAULT
) (
   input  sdm_pkg::req_type        req,
   input  sdm_pkg::action_type     ent,
   input  sdm_pkg::proc_state_type cur,
   output sdm_pkg::rsp_type        rsp,
   output logic                    act_wr,
   output sdm_pkg::action_type     act_wdata,
   output sdm_pkg::proc_state_type nxt
);

   localparam logic [6:0] MAX_SIG_V = 7'(MAX_SIG);

   logic        sig_ok;
   logic        sig_prot;
   logic [63:0] sig_bit;

   assign sig_ok   = (req.signal_number != 7'd0) && (req.signal_number <= MAX_SIG_V);
   assign sig_prot = (req.signal_number == sdm_pkg::SIG_KILL) ||
                     (req.signal_number == sdm_pkg::SIG_STOP);
   assign sig_bit  = 64'd1 << req.signal_number[sdm_pkg::MASK_IDX_W-1:0];

   always_comb begin
      logic [63:0] opnd;
      logic [63:0] nm;
      rsp                 = '0;
      rsp.status          = sdm_pkg::STATUS_OK;
      rsp.disposition     = sdm_pkg::DISP_HANDLER;
      rsp.old_signal_mask = cur.blocked;
      act_wr              = 1'b0;
      act_wdata           = ent;
      nxt                 = cur;
      opnd                = '0;
      nm                  = '0;

      unique case (req.opcode)
         sdm_pkg::OP_SET_ACTION, sdm_pkg::OP_RESET_ACTION: begin
            if (!sig_ok || sig_prot) begin
               rsp.status = sdm_pkg::STATUS_INV;
            end else begin
               rsp.handler_address = ent.handler;
               rsp.flags_out       = ent.flags;
               rsp.action_mask_out = ent.amask;
               act_wr              = 1'b1;
               if (req.opcode == sdm_pkg::OP_SET_ACTION) begin
                  act_wdata.installed = 1'b1;
                  act_wdata.handler   = req.handler_value;
                  act_wdata.flags     = req.action_flag_bits & sdm_pkg::FL_SUPPORTED;
                  act_wdata.amask     = req.set_value;
               end else begin
                  act_wdata = '0;
               end
            end
         end
         sdm_pkg::OP_CHANGE_MASK: begin
            if (req.set_size != sdm_pkg::SET_SIZE_4 && req.set_size != sdm_pkg::SET_SIZE_8) begin
               rsp.status          = sdm_pkg::STATUS_INV;
               rsp.old_signal_mask = '0;
            end else begin
               if (req.set_size == sdm_pkg::SET_SIZE_4) begin
                  rsp.old_signal_mask = cur.blocked & sdm_pkg::LOW_WORD;
                  opnd                = req.set_value & sdm_pkg::LOW_WORD;
               end else begin
                  opnd = req.set_value;
               end
               opnd = opnd & ~sdm_pkg::UNBLOCKABLE;
               if (req.has_new_set) begin
                  unique case (req.mask_how)
                     sdm_pkg::HOW_BLOCK:   nxt.blocked = cur.blocked | opnd;
                     sdm_pkg::HOW_UNBLOCK: nxt.blocked = cur.blocked & ~opnd;
                     sdm_pkg::HOW_SETMASK: nxt.blocked = opnd;
                     sdm_pkg::HOW_BAD:     rsp.status  = sdm_pkg::STATUS_INV;
                     default:              rsp.status  = sdm_pkg::STATUS_INV;
                  endcase
               end
            end
         end
         sdm_pkg::OP_DELIVER: begin
            if (!sig_ok) begin
               rsp.status      = sdm_pkg::STATUS_INV;
               rsp.disposition = sdm_pkg::DISP_INVALID;
            end else if (((cur.blocked & sig_bit) != '0) && !sig_prot) begin
               rsp.disposition = sdm_pkg::DISP_BLOCKED;
            end else if (ent.installed && ent.handler == sdm_pkg::HANDLER_IGN) begin
               rsp.disposition = sdm_pkg::DISP_IGNORED;
            end else if (!ent.installed || ent.handler == sdm_pkg::HANDLER_DFL) begin
               if ((sdm_pkg::TERM_SET & sig_bit) != '0) begin
                  rsp.disposition = sdm_pkg::DISP_TERMINATE;
                  nxt.stopped     = 1'b1;
                  nxt.exit_value  = sdm_pkg::EXIT_BASE + {1'b0, req.signal_number};
                  rsp.core_dump   = (sdm_pkg::CORE_SET & sig_bit) != '0;
               end else begin
                  rsp.disposition = sdm_pkg::DISP_DFL_IGN;
               end
            end else begin
               rsp.disposition     = sdm_pkg::DISP_HANDLER;
               rsp.handler_address = ent.handler;
               nm                  = cur.blocked | ent.amask;
               if ((ent.flags & sdm_pkg::FL_NODEFER) == '0) begin
                  nm = nm | sig_bit;
               end
               nxt.blocked = nm & ~sdm_pkg::UNBLOCKABLE;
               if ((ent.flags & sdm_pkg::FL_RESETHAND) != '0) begin
                  act_wr            = 1'b1;
                  act_wdata.handler = sdm_pkg::HANDLER_DFL;
               end
            end
         end
         default: rsp.status = sdm_pkg::STATUS_INV;
      endcase

      rsp.new_signal_mask = nxt.blocked;
      rsp.exit_value      = nxt.exit_value;
      rsp.terminated      = nxt.stopped;
   end

endmodule

// ===== hdl/signal_disposition_mask_unit.sv =====
// Top level of the signal disposition mask unit: sequencer, process state
// and response register. Uses sdm_pkg, sdm_if, sdm_action_ram, sdm_engine.
//
// A request is accepted in ST_IDLE, which issues the action-table read for
// the request's signal; ST_EXEC then evaluates the request against the
// registered entry and, on commit, writes the entry back and loads the
// response register. No new request is accepted until the block is back in
// ST_IDLE. A response waiting on a stalled sink holds the block in evaluation
// until it is taken, so the table and mask never run ahead of delivered beats.
// The table reads as all zero after reset through per-entry valid flops; no
// clearing pass.
`include "signal_disposition_mask_unit_macros.svh"

module signal_disposition_mask_unit #(
   parameter int MAX_SIG = sdm_pkg::MAX_SIG_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   sdm_req_if.sink      req_bus,
   sdm_rsp_if.source    rsp_bus
);

   localparam int DEPTH  = MAX_SIG + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } seq_state_type;

   seq_state_type           state_ff;
   seq_state_type           state_in;
   sdm_pkg::req_type        req_ff;
   sdm_pkg::req_type        req_in;
   sdm_pkg::proc_state_type pst_ff;
   sdm_pkg::proc_state_type pst_in;
   sdm_pkg::rsp_type        rsp_ff;
   sdm_pkg::rsp_type        rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic                    req_beat;
   logic                    commit;
   sdm_pkg::action_type     ent;
   sdm_pkg::rsp_type        eng_rsp;
   logic                    eng_wr;
   sdm_pkg::action_type     eng_wdata;
   sdm_pkg::proc_state_type eng_nxt;
   logic                    ram_wr;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign commit        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);
   assign ram_wr        = commit && eng_wr;

   sdm_action_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_beat),
      .rd_addr (req_bus.signal_number[ADDR_W-1:0]),
      .rd_data (ent),
      .wr_en   (ram_wr),
      .wr_addr (req_ff.signal_number[ADDR_W-1:0]),
      .wr_data (eng_wdata)
   );

   sdm_engine #(
      .MAX_SIG (MAX_SIG)
   ) u_engine (
      .req       (req_ff),
      .ent       (ent),
      .cur       (pst_ff),
      .rsp       (eng_rsp),
      .act_wr    (eng_wr),
      .act_wdata (eng_wdata),
      .nxt       (eng_nxt)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      if (req_beat) begin
         req_in.opcode           = req_bus.opcode;
         req_in.signal_number    = req_bus.signal_number;
         req_in.handler_value    = req_bus.handler_value;
         req_in.action_flag_bits = req_bus.action_flag_bits;
         req_in.set_value        = req_bus.set_value;
         req_in.mask_how         = req_bus.mask_how;
         req_in.has_new_set      = req_bus.has_new_set;
         req_in.set_size         = req_bus.set_size;
      end
   end

   assign pst_in       = commit ? eng_nxt : pst_ff;
   assign rsp_in       = commit ? eng_rsp : rsp_ff;
   assign rsp_valid_in = commit ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pst_ff       <= pst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_ff.status;
   assign rsp_bus.disposition     = rsp_ff.disposition;
   assign rsp_bus.handler_address = rsp_ff.handler_address;
   assign rsp_bus.flags_out       = rsp_ff.flags_out;
   assign rsp_bus.action_mask_out = rsp_ff.action_mask_out;
   assign rsp_bus.old_signal_mask = rsp_ff.old_signal_mask;
   assign rsp_bus.new_signal_mask = rsp_ff.new_signal_mask;
   assign rsp_bus.exit_value      = rsp_ff.exit_value;
   assign rsp_bus.core_dump       = rsp_ff.core_dump;
   assign rsp_bus.terminated      = rsp_ff.terminated;

   `SDM_ASSERT_NEXT(a_beat_enters_exec, clock, reset, req_beat, state_ff == ST_EXEC)
   `SDM_ASSERT_HOLDS(a_write_on_commit, clock, reset, ram_wr, state_ff == ST_EXEC)
   `SDM_ASSERT_HOLDS(a_kill_stop_open, clock, reset, 1'b1, ~|(pst_ff.blocked & sdm_pkg::UNBLOCKABLE))
   `SDM_ASSERT_NEXT(a_stopped_sticky, clock, reset, pst_ff.stopped, pst_ff.stopped)

endmodule

// ===== test/sdm_outcome_checker.sv =====
`timescale 1ns / 1ps
// Outcome checker for the signal disposition mask unit: predicts each response
// from accepted request beats and compares it field by field. Uses sdm_pkg, sdm_if.
module sdm_outcome_checker #(
   parameter int MAX_SIG = sdm_pkg::MAX_SIG_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   sdm_req_if   req_mon,
   sdm_rsp_if   rsp_mon,
   output int   error_count,
   output int   outstanding
);
   import sdm_pkg::*;

   logic [63:0] action_handler   [64];
   logic [31:0] action_flags     [64];
   logic [63:0] action_mask      [64];
   logic        action_installed [64];
   logic [63:0] blocked_set;
   logic        proc_stopped;
   logic [7:0]  proc_exit_value;

   rsp_type predicted_outcomes[$];
   rsp_type want, seen;
   req_type beat;

   function automatic rsp_type predict_outcome(req_type r);
      rsp_type     o;
      logic        sig_ok;
      logic [5:0]  idx;
      logic [63:0] sig_bit;
      logic [63:0] opnd;
      logic [63:0] nm;
      o = '0;
      o.old_signal_mask = blocked_set;
      sig_ok = (r.signal_number != 7'd0) && (r.signal_number <= MAX_SIG);
      idx = r.signal_number[5:0];
      sig_bit = 64'd1 << idx;
      case (r.opcode)
         OP_SET_ACTION, OP_RESET_ACTION: begin
            if (!sig_ok || r.signal_number == SIG_KILL || r.signal_number == SIG_STOP) begin
               o.status = STATUS_INV;
            end else begin
               o.handler_address = action_handler[idx];
               o.flags_out       = action_flags[idx];
               o.action_mask_out = action_mask[idx];
               if (r.opcode == OP_SET_ACTION) begin
                  action_handler[idx]   = r.handler_value;
                  action_flags[idx]     = r.action_flag_bits & FL_SUPPORTED;
                  action_mask[idx]      = r.set_value;
                  action_installed[idx] = 1'b1;
               end else begin
                  action_handler[idx]   = '0;
                  action_flags[idx]     = '0;
                  action_mask[idx]      = '0;
                  action_installed[idx] = 1'b0;
               end
            end
         end
         OP_CHANGE_MASK: begin
            if (r.set_size != SET_SIZE_4 && r.set_size != SET_SIZE_8) begin
               o.status = STATUS_INV;
               o.old_signal_mask = '0;
            end else begin
               if (r.set_size == SET_SIZE_4) o.old_signal_mask &= LOW_WORD;
               if (r.has_new_set) begin
                  opnd = (r.set_size == SET_SIZE_4) ? (r.set_value & LOW_WORD) : r.set_value;
                  opnd &= ~UNBLOCKABLE;
                  case (r.mask_how)
                     HOW_BLOCK:   blocked_set = blocked_set | opnd;
                     HOW_UNBLOCK: blocked_set = blocked_set & ~opnd;
                     HOW_SETMASK: blocked_set = opnd;
                     default:     o.status = STATUS_INV;
                  endcase
               end
            end
         end
         default: begin
            if (!sig_ok) begin
               o.status = STATUS_INV;
               o.disposition = DISP_INVALID;
            end else if ((blocked_set & sig_bit) != 0 && r.signal_number != SIG_KILL &&
                         r.signal_number != SIG_STOP) begin
               o.disposition = DISP_BLOCKED;
            end else if (action_installed[idx] && action_handler[idx] == HANDLER_IGN) begin
               o.disposition = DISP_IGNORED;
            end else if (!action_installed[idx] || action_handler[idx] == HANDLER_DFL) begin
               if ((TERM_SET & sig_bit) != 0) begin
                  o.disposition = DISP_TERMINATE;
                  proc_stopped = 1'b1;
                  proc_exit_value = EXIT_BASE + 8'(r.signal_number);
                  o.core_dump = (CORE_SET & sig_bit) != 0;
               end else begin
                  o.disposition = DISP_DFL_IGN;
               end
            end else begin
               nm = blocked_set | action_mask[idx];
               o.disposition = DISP_HANDLER;
               o.handler_address = action_handler[idx];
               if ((action_flags[idx] & FL_NODEFER) == 0) nm |= sig_bit;
               blocked_set = nm & ~UNBLOCKABLE;
               if ((action_flags[idx] & FL_RESETHAND) != 0) action_handler[idx] = HANDLER_DFL;
            end
         end
      endcase
      o.new_signal_mask = blocked_set;
      o.exit_value = proc_exit_value;
      o.terminated = proc_stopped;
      return o;
   endfunction

   function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %h, actual %h", name, exp_val, act_val);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (action_handler[i]) begin
            action_handler[i]   = '0;
            action_flags[i]     = '0;
            action_mask[i]      = '0;
            action_installed[i] = 1'b0;
         end
         blocked_set = '0;
         proc_stopped = 1'b0;
         proc_exit_value = '0;
         predicted_outcomes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status          = rsp_mon.status;
            seen.disposition     = rsp_mon.disposition;
            seen.handler_address = rsp_mon.handler_address;
            seen.flags_out       = rsp_mon.flags_out;
            seen.action_mask_out = rsp_mon.action_mask_out;
            seen.old_signal_mask = rsp_mon.old_signal_mask;
            seen.new_signal_mask = rsp_mon.new_signal_mask;
            seen.exit_value      = rsp_mon.exit_value;
            seen.core_dump       = rsp_mon.core_dump;
            seen.terminated      = rsp_mon.terminated;
            if (predicted_outcomes.size() == 0) begin
               $error("response beat with no request waiting");
               error_count++;
            end else begin
               want = predicted_outcomes.pop_front();
               compare_field("status", want.status, seen.status);
               compare_field("disposition", want.disposition, seen.disposition);
               compare_field("handler_address", want.handler_address, seen.handler_address);
               compare_field("flags_out", want.flags_out, seen.flags_out);
               compare_field("action_mask_out", want.action_mask_out, seen.action_mask_out);
               compare_field("old_signal_mask", want.old_signal_mask, seen.old_signal_mask);
               compare_field("new_signal_mask", want.new_signal_mask, seen.new_signal_mask);
               compare_field("exit_value", want.exit_value, seen.exit_value);
               compare_field("core_dump", want.core_dump, seen.core_dump);
               compare_field("terminated", want.terminated, seen.terminated);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            beat.opcode           = req_mon.opcode;
            beat.signal_number    = req_mon.signal_number;
            beat.handler_value    = req_mon.handler_value;
            beat.action_flag_bits = req_mon.action_flag_bits;
            beat.set_value        = req_mon.set_value;
            beat.mask_how         = req_mon.mask_how;
            beat.has_new_set      = req_mon.has_new_set;
            beat.set_size         = req_mon.set_size;
            predicted_outcomes.push_back(predict_outcome(beat));
         end
      end
      outstanding = predicted_outcomes.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the signal disposition mask unit: clock, reset, request
// stimulus, response stalls, watchdog and verdict. Uses sdm_pkg, sdm_if, sdm_outcome_checker.
module tb;
   import sdm_pkg::*;

   localparam int RANDOM_BEATS   = 1000;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   outstanding;
   int   burst_left;
   int   idle_cycles;

   sdm_req_if req_bus ();
   sdm_rsp_if rsp_bus ();

   signal_disposition_mask_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sdm_outcome_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .error_count (mismatch_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int ready_mode;
      int mode_left;
      int phase;
      ready_mode = 0;
      mode_left = 0;
      phase = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         phase++;
         case (ready_mode)
            0: rsp_bus.ready = 1'b1;
            1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready = ((phase % 7) < 3);
            default: rsp_bus.ready = ($urandom_range(0, 1) == 1);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] opcode, logic [6:0] sig,
                                        logic [63:0] handler, logic [31:0] flags,
                                        logic [63:0] set_val, logic [1:0] how,
                                        logic has_new, logic [3:0] size);
      req_type r;
      r.opcode           = opcode;
      r.signal_number    = sig;
      r.handler_value    = handler;
      r.action_flag_bits = flags;
      r.set_value        = set_val;
      r.mask_how         = how;
      r.has_new_set      = has_new;
      r.set_size         = size;
      return r;
   endfunction

   function automatic logic [6:0] pick_signal();
      case ($urandom_range(0, 11))
         0: return 7'($urandom_range(64, 127));
         1: return SIG_KILL;
         2: return SIG_STOP;
         3: return 7'd0;
         default: return 7'($urandom_range(1, 63));
      endcase
   endfunction

   function automatic logic [63:0] pick_handler();
      case ($urandom_range(0, 4))
         0: return HANDLER_DFL;
         1: return HANDLER_IGN;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] pick_set();
      case ($urandom_range(0, 7))
         0: return '1;
         1: return {$urandom, $urandom};
         2: return '0;
         default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) r.opcode = OP_SET_ACTION;
      else if (pick < 40) r.opcode = OP_RESET_ACTION;
      else if (pick < 65) r.opcode = OP_CHANGE_MASK;
      else r.opcode = OP_DELIVER;
      r.signal_number    = pick_signal();
      r.handler_value    = pick_handler();
      r.action_flag_bits = $urandom;
      r.set_value        = pick_set();
      r.mask_how         = 2'($urandom_range(0, 3));
      r.has_new_set      = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) == 0) r.set_size = 4'($urandom_range(0, 15));
      else r.set_size = $urandom_range(0, 1) ? SET_SIZE_4 : SET_SIZE_8;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid            = 1'b1;
      req_bus.opcode           = r.opcode;
      req_bus.signal_number    = r.signal_number;
      req_bus.handler_value    = r.handler_value;
      req_bus.action_flag_bits = r.action_flag_bits;
      req_bus.set_value        = r.set_value;
      req_bus.mask_how         = r.mask_how;
      req_bus.has_new_set      = r.has_new_set;
      req_bus.set_size         = r.set_size;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_bus.valid = 1'b0;
      burst_left = 0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int      sent;
      int      repeats;
      req_type r;
      logic [6:0] sig;
      reset = 1'b1;
      burst_left = 0;
      req_bus.valid            = 1'b0;
      req_bus.opcode           = OP_SET_ACTION;
      req_bus.signal_number    = '0;
      req_bus.handler_value    = '0;
      req_bus.action_flag_bits = '0;
      req_bus.set_value        = '0;
      req_bus.mask_how         = HOW_BLOCK;
      req_bus.has_new_set      = 1'b0;
      req_bus.set_size         = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(make_req(OP_CHANGE_MASK, 7'd1, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_8));
      send_request(make_req(OP_SET_ACTION, 7'd0, '1, '1, '1, HOW_BLOCK, 1'b1, SET_SIZE_8));
      send_request(make_req(OP_SET_ACTION, 7'd127, '1, '1, '1, HOW_BLOCK, 1'b1, SET_SIZE_8));
      send_request(make_req(OP_SET_ACTION, SIG_KILL, 64'h1234, '1, '1, HOW_BLOCK, 1'b1,
                            SET_SIZE_8));
      send_request(make_req(OP_RESET_ACTION, SIG_STOP, '0, '0, '0, HOW_BLOCK, 1'b0,
                            SET_SIZE_4));
      send_request(make_req(OP_SET_ACTION, 7'd1, '1, '1, '1, HOW_SETMASK, 1'b1, 4'd15));
      send_request(make_req(OP_RESET_ACTION, 7'd1, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_SET_ACTION, 7'd63, HANDLER_IGN, '0, '0, HOW_BLOCK, 1'b0,
                            SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd63, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_SET_ACTION, 7'd2, HANDLER_DFL, '0, '0, HOW_BLOCK, 1'b0,
                            SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd2, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd0, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd127, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd17, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd11, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_SET_ACTION, 7'd10, 64'hFFFF_8000_0040_1000,
                            FL_RESETHAND | FL_NODEFER, 64'h0000_0000_0008_02F0, HOW_BLOCK,
                            1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd10, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd10, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_SET_ACTION, 7'd12, 64'h0000_0000_0040_2000, '0, '0,
                            HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, 7'd12, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_CHANGE_MASK, 7'd1, '0, '0, '1, HOW_BLOCK, 1'b1, SET_SIZE_8));
      send_request(make_req(OP_DELIVER, 7'd15, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_DELIVER, SIG_KILL, '0, '0, '0, HOW_BLOCK, 1'b0, SET_SIZE_4));
      send_request(make_req(OP_CHANGE_MASK, 7'd1, '0, '0, '1, HOW_UNBLOCK, 1'b1, SET_SIZE_4));
      send_request(make_req(OP_CHANGE_MASK, 7'd1, '0, '0, '1, HOW_BAD, 1'b1, SET_SIZE_8));
      send_request(make_req(OP_CHANGE_MASK, 7'd1, '0, '0, '0, HOW_SETMASK, 1'b1, 4'd0));
      send_request(make_req(OP_CHANGE_MASK, 7'd1, '0, '0, '0, HOW_SETMASK, 1'b1, SET_SIZE_8));
      drain_responses();

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         if (sent % 256 == 255) drain_responses();
         if ($urandom_range(0, 2) == 0) begin
            sig = 7'($urandom_range(1, 63));
            if ($urandom_range(0, 3) == 0) begin
               send_request(make_req(OP_CHANGE_MASK, pick_signal(), {$urandom, $urandom},
                                     $urandom, '1, HOW_UNBLOCK, 1'b1, SET_SIZE_8));
               sent++;
            end
            r = random_req();
            r.opcode = OP_SET_ACTION;
            r.signal_number = sig;
            send_request(r);
            sent++;
            repeats = $urandom_range(1, 3);
            repeat (repeats) begin
               r = random_req();
               r.opcode = OP_DELIVER;
               r.signal_number = sig;
               send_request(r);
               sent++;
            end
         end else begin
            send_request(random_req());
            sent++;
         end
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
